### sv/rosi_pkg.sv
// Shared constants, register codes and lane helpers for the ray / oriented box slab test.
// No dependencies; used by rosi_div and ray_obb_slab_intersect_top.
package rosi_pkg;

    localparam int CW      = 16;          // coordinate width, Q8.8
    localparam int REG_W   = 48;          // configuration register width
    localparam int IDX_W   = 3;           // configuration index width
    localparam int MAXD_W  = 15;          // max distance / hit distance width
    localparam int REL_W   = CW + 1;      // origin minus center
    localparam int P_W     = 2 * CW + 3;  // box-space origin, sum of three products
    localparam int Q_W     = 2 * CW + 2;  // box-space direction
    localparam int H_W     = 31;          // half extent scaled by 2^14, signed
    localparam int N_W     = P_W + 1;     // slab numerator before scaling
    localparam int LEN_W   = 24;          // direction length, Q.16
    localparam int LENS_W  = LEN_W + 1;   // length as a signed operand
    localparam int NUM1_W  = N_W + LENS_W;
    localparam int QW1     = 25;          // slab distance quotient bits (saturating)
    localparam int T_W     = QW1 + 1;
    localparam int TMIN_W  = 23;
    localparam int PD_W    = CW + TMIN_W + 1;
    localparam int PQ_W    = Q_W + TMIN_W + 1;
    localparam int QW2     = 32;          // hit point quotient bits
    localparam int LOC_W   = P_W + 1;
    localparam int BD_W    = LOC_W + 1;

    typedef enum logic [IDX_W-1:0] {
        REG_CENTER = 3'd0,
        REG_AXIS_X = 3'd1,
        REG_AXIS_Y = 3'd2,
        REG_AXIS_Z = 3'd3,
        REG_HALF   = 3'd4
    } reg_idx_t;

    localparam logic [REG_W-1:0] RST_CENTER = 48'h0000_0000_0000;
    localparam logic [REG_W-1:0] RST_AXIS_X = 48'h0000_0000_4000;
    localparam logic [REG_W-1:0] RST_AXIS_Y = 48'h0000_4000_0000;
    localparam logic [REG_W-1:0] RST_AXIS_Z = 48'h4000_0000_0000;
    localparam logic [REG_W-1:0] RST_HALF   = 48'h0000_0000_0000;

    // pipeline depth of rosi_div for a given quotient width
    function automatic int div_lat(input int qw);
        return qw + 3;
    endfunction

    function automatic logic signed [CW-1:0] lane_s(input logic [REG_W-1:0] r, input int k);
        return r[16*k +: 16];
    endfunction

endpackage

### sv/ray_obb_slab_intersect_top.sv
// Ray against oriented box, slab method, as one deep pipeline.
// Depends on rosi_pkg and rosi_div (pipelined dividers for slab and hit point math).
//
// Usage:
//   Configure the box through cfg_wr_en / cfg_index / cfg_data while no request
//   is in flight: center, three axes (Q1.14 lanes) and half extents.
//   Rays arrive on the s_axis stream, one per beat; results leave on m_axis.
//   Throughput is one ray per cycle: the length square root (24 stages) and
//   two banks of bit-per-stage dividers (28 and 35 stages) are fully pipelined.
//   When m_axis_tready is low with a valid result held, the whole pipeline
//   freezes and s_axis_tready drops; nothing is lost or repeated.
//   Reset clears all valid bits and loads the identity box at the origin with
//   zero half extents.
//   A zero direction misses. A miss returns all-zero fields.
//   s_axis_tdata and m_axis_tdata are 112 bits each (fields listed at the ports).
module ray_obb_slab_intersect_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [rosi_pkg::IDX_W-1:0]     cfg_index,
    input  logic [rosi_pkg::REG_W-1:0]     cfg_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // ray_origin_x, ray_origin_y, ray_origin_z, ray_dir_x, ray_dir_y, ray_dir_z,
    // max_distance (15), one pad bit
    input  logic [111:0]                   s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // is_hit, hit_distance (15), hit_pos_x, hit_pos_y, hit_pos_z,
    // normal_x, normal_y, normal_z
    output logic [111:0]                   m_axis_tdata
);

    localparam int CW      = rosi_pkg::CW;
    localparam int SQ_N    = rosi_pkg::LEN_W;
    localparam int S_PQ    = 1;
    localparam int S_LEN   = SQ_N + 1;
    localparam int S_MUL   = S_LEN + 1;
    localparam int DL1     = rosi_pkg::div_lat(rosi_pkg::QW1);
    localparam int S_CLIP1 = S_MUL + DL1 + 1;
    localparam int S_CLIP2 = S_CLIP1 + 1;
    localparam int S_MUL2  = S_CLIP2 + 1;
    localparam int DL2     = rosi_pkg::div_lat(rosi_pkg::QW2);
    localparam int S_FIN1  = S_MUL2 + DL2 + 1;
    localparam int S_FIN2  = S_FIN1 + 1;
    localparam int NST     = S_FIN2 + 1;
    localparam int SQR_W   = 50;

    typedef struct packed {
        logic [2:0][CW-1:0]                  o;
        logic [2:0][CW-1:0]                  d;
        logic [rosi_pkg::MAXD_W-1:0]         maxd;
        logic [2:0][rosi_pkg::REL_W-1:0]     rel;
        logic [31:0]                         len2;
        logic                                zero;
        logic [2:0][rosi_pkg::P_W-1:0]       p;
        logic [2:0][rosi_pkg::Q_W-1:0]       q;
        logic [rosi_pkg::LEN_W-1:0]          len;
        logic [2:0][rosi_pkg::NUM1_W-1:0]    n1;
        logic [2:0][rosi_pkg::NUM1_W-1:0]    n2;
        logic [2:0][rosi_pkg::T_W-1:0]       lo;
        logic [2:0][rosi_pkg::T_W-1:0]       hi;
        logic                                par_miss;
        logic [rosi_pkg::TMIN_W-1:0]         tmin;
        logic                                hit;
        logic [2:0][rosi_pkg::PD_W-1:0]      pd;
        logic [2:0][rosi_pkg::PQ_W-1:0]      pq;
        logic [2:0][CW-1:0]                  hp;
        logic [2:0][rosi_pkg::LOC_W-1:0]     loc;
        logic [2:0][rosi_pkg::BD_W-1:0]      bd;
        logic [2:0][CW-1:0]                  nrm;
        logic [rosi_pkg::MAXD_W-1:0]         hdist;
    } side_t;

    // configuration
    logic [rosi_pkg::REG_W-1:0] center_reg;
    logic [rosi_pkg::REG_W-1:0] axis_reg [3];
    logic [rosi_pkg::REG_W-1:0] half_reg;
    logic signed [CW-1:0]               c_s  [3];
    logic signed [CW-1:0]               ax_s [3][3];
    logic signed [rosi_pkg::H_W-1:0]    h_s  [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg  <= rosi_pkg::RST_CENTER;
            axis_reg[0] <= rosi_pkg::RST_AXIS_X;
            axis_reg[1] <= rosi_pkg::RST_AXIS_Y;
            axis_reg[2] <= rosi_pkg::RST_AXIS_Z;
            half_reg    <= rosi_pkg::RST_HALF;
        end
        else if (cfg_wr_en)
        begin
            case (rosi_pkg::reg_idx_t'(cfg_index))
                rosi_pkg::REG_CENTER: center_reg  <= cfg_data;
                rosi_pkg::REG_AXIS_X: axis_reg[0] <= cfg_data;
                rosi_pkg::REG_AXIS_Y: axis_reg[1] <= cfg_data;
                rosi_pkg::REG_AXIS_Z: axis_reg[2] <= cfg_data;
                rosi_pkg::REG_HALF:   half_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            c_s[k] = rosi_pkg::lane_s(center_reg, k);
            h_s[k] = $signed({1'b0, half_reg[16*k +: 16], 14'b0});
            for (int i = 0; i < 3; i++)
                ax_s[k][i] = rosi_pkg::lane_s(axis_reg[k], i);
        end
    end

    // pipeline
    side_t            st_reg  [NST];
    side_t            st_next [NST];
    logic [NST-1:0]   vld_reg;
    logic             en;

    logic [SQR_W-1:0]           sq_rem_reg  [SQ_N];
    logic [rosi_pkg::LEN_W-1:0] sq_res_reg  [SQ_N];
    logic [SQR_W-1:0]           sq_rem_next [SQ_N];
    logic [rosi_pkg::LEN_W-1:0] sq_res_next [SQ_N];

    logic signed [rosi_pkg::T_W-1:0] t1q [3];
    logic signed [rosi_pkg::T_W-1:0] t2q [3];
    logic signed [rosi_pkg::QW2:0]   hq  [3];
    logic signed [rosi_pkg::QW2:0]   lq  [3];

    assign en            = !vld_reg[NST-1] || m_axis_tready;
    assign s_axis_tready = en;

    // length square root, one result bit per stage
    always_comb
    begin
        logic [SQR_W-1:0]           rin;
        logic [rosi_pkg::LEN_W-1:0] resin;
        logic [SQR_W-1:0]           trial;
        for (int j = 0; j < SQ_N; j++)
        begin
            rin   = (j == 0) ? {2'b0, st_reg[0].len2, 16'b0} : sq_rem_reg[j-1];
            resin = (j == 0) ? '0 : sq_res_reg[j-1];
            trial = (SQR_W'(resin) << (SQ_N - j)) | (SQR_W'(1) << (2 * (SQ_N - 1 - j)));
            if (rin >= trial)
            begin
                sq_rem_next[j] = rin - trial;
                sq_res_next[j] = resin | (rosi_pkg::LEN_W'(1) << (SQ_N - 1 - j));
            end
            else
            begin
                sq_rem_next[j] = rin;
                sq_res_next[j] = resin;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < SQ_N; j++)
            begin
                sq_rem_reg[j] <= sq_rem_next[j];
                sq_res_reg[j] <= sq_res_next[j];
            end
        end
    end

    genvar gk;
    generate
        for (gk = 0; gk < 3; gk++)
        begin : g_div
            rosi_div #(
                .NW(rosi_pkg::NUM1_W), .DW(rosi_pkg::Q_W), .QW(rosi_pkg::QW1)
            ) u_div_lo (
                .clk(clk), .en(en),
                .num($signed(st_reg[S_MUL].n1[gk])),
                .den($signed(st_reg[S_MUL].q[gk])),
                .quo(t1q[gk])
            );
            rosi_div #(
                .NW(rosi_pkg::NUM1_W), .DW(rosi_pkg::Q_W), .QW(rosi_pkg::QW1)
            ) u_div_hi (
                .clk(clk), .en(en),
                .num($signed(st_reg[S_MUL].n2[gk])),
                .den($signed(st_reg[S_MUL].q[gk])),
                .quo(t2q[gk])
            );
            rosi_div #(
                .NW(rosi_pkg::PD_W), .DW(rosi_pkg::LENS_W), .QW(rosi_pkg::QW2)
            ) u_div_pos (
                .clk(clk), .en(en),
                .num($signed(st_reg[S_MUL2].pd[gk])),
                .den($signed({1'b0, st_reg[S_MUL2].len})),
                .quo(hq[gk])
            );
            rosi_div #(
                .NW(rosi_pkg::PQ_W), .DW(rosi_pkg::LENS_W), .QW(rosi_pkg::QW2)
            ) u_div_loc (
                .clk(clk), .en(en),
                .num($signed(st_reg[S_MUL2].pq[gk])),
                .den($signed({1'b0, st_reg[S_MUL2].len})),
                .quo(lq[gk])
            );
        end
    endgenerate

    always_comb
    begin
        logic signed [CW-1:0]                oi;
        logic signed [CW-1:0]                di;
        logic signed [31:0]                  sq;
        logic signed [2*CW:0]                prod_p;
        logic signed [2*CW-1:0]              prod_q;
        logic signed [rosi_pkg::P_W-1:0]     pk;
        logic signed [rosi_pkg::Q_W-1:0]     qk;
        logic signed [rosi_pkg::N_W-1:0]     nlo;
        logic signed [rosi_pkg::N_W-1:0]     nhi;
        logic signed [rosi_pkg::N_W-1:0]     ps;
        logic signed [rosi_pkg::N_W-1:0]     hs;
        logic signed [rosi_pkg::LENS_W-1:0]  len_s;
        logic signed [rosi_pkg::NUM1_W-1:0]  m1;
        logic signed [rosi_pkg::NUM1_W-1:0]  m2;
        logic signed [rosi_pkg::T_W-1:0]     tlo;
        logic signed [rosi_pkg::T_W-1:0]     thi;
        logic signed [rosi_pkg::TMIN_W:0]    tm_s;
        logic signed [rosi_pkg::PD_W-1:0]    mpd;
        logic signed [rosi_pkg::PQ_W-1:0]    mpq;
        logic signed [CW+rosi_pkg::QW2+1:0]  hsum;
        logic signed [rosi_pkg::LOC_W-1:0]   lsum;
        logic signed [rosi_pkg::LOC_W-1:0]   labs;
        logic signed [rosi_pkg::BD_W-1:0]    bd0;
        logic signed [rosi_pkg::BD_W-1:0]    bd1;
        logic signed [rosi_pkg::BD_W-1:0]    bd2;
        logic [1:0]                          sel;
        logic signed [CW-1:0]                a;
        logic [31:0]                         l2;

        for (int s = 1; s < NST; s++)
            st_next[s] = st_reg[s-1];

        // input capture: origin minus center, squared length
        st_next[0] = '0;
        l2 = '0;
        for (int i = 0; i < 3; i++)
        begin
            oi = s_axis_tdata[16*i +: 16];
            di = s_axis_tdata[48 + 16*i +: 16];
            st_next[0].o[i]   = oi;
            st_next[0].d[i]   = di;
            st_next[0].rel[i] = rosi_pkg::REL_W'(oi) - rosi_pkg::REL_W'(c_s[i]);
            sq = di * di;
            l2 = l2 + 32'(sq);
        end
        st_next[0].maxd = s_axis_tdata[110:96];
        st_next[0].len2 = l2;
        st_next[0].zero = (l2 == '0);

        // box-space origin and direction
        for (int k = 0; k < 3; k++)
        begin
            pk = '0;
            qk = '0;
            for (int i = 0; i < 3; i++)
            begin
                prod_p = $signed(st_reg[S_PQ-1].rel[i]) * ax_s[k][i];
                prod_q = $signed(st_reg[S_PQ-1].d[i]) * ax_s[k][i];
                pk = pk + rosi_pkg::P_W'(prod_p);
                qk = qk + rosi_pkg::Q_W'(prod_q);
            end
            st_next[S_PQ].p[k] = pk;
            st_next[S_PQ].q[k] = qk;
        end

        st_next[S_LEN].len = sq_res_reg[SQ_N-1];

        // slab numerators scaled by the length
        len_s = $signed({1'b0, st_reg[S_MUL-1].len});
        for (int k = 0; k < 3; k++)
        begin
            ps  = rosi_pkg::N_W'($signed(st_reg[S_MUL-1].p[k]));
            hs  = rosi_pkg::N_W'(h_s[k]);
            nlo = -hs - ps;
            nhi = hs - ps;
            m1  = nlo * len_s;
            m2  = nhi * len_s;
            st_next[S_MUL].n1[k] = m1;
            st_next[S_MUL].n2[k] = m2;
        end

        // per-axis entry/exit, parallel axes tested against the slab
        st_next[S_CLIP1].par_miss = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            ps = rosi_pkg::N_W'($signed(st_reg[S_CLIP1-1].p[k]));
            hs = rosi_pkg::N_W'(h_s[k]);
            if (st_reg[S_CLIP1-1].q[k] == '0)
            begin
                st_next[S_CLIP1].lo[k] = '0;
                st_next[S_CLIP1].hi[k] = {1'b0, {(rosi_pkg::T_W-1){1'b1}}};
                if (ps < -hs || ps > hs)
                    st_next[S_CLIP1].par_miss = 1'b1;
            end
            else if (t1q[k] > t2q[k])
            begin
                st_next[S_CLIP1].lo[k] = t2q[k];
                st_next[S_CLIP1].hi[k] = t1q[k];
            end
            else
            begin
                st_next[S_CLIP1].lo[k] = t1q[k];
                st_next[S_CLIP1].hi[k] = t2q[k];
            end
        end

        // interval intersection
        tlo = '0;
        thi = $signed(rosi_pkg::T_W'({st_reg[S_CLIP2-1].maxd, 8'b0}));
        for (int k = 0; k < 3; k++)
        begin
            if ($signed(st_reg[S_CLIP2-1].lo[k]) > tlo)
                tlo = $signed(st_reg[S_CLIP2-1].lo[k]);
            if ($signed(st_reg[S_CLIP2-1].hi[k]) < thi)
                thi = $signed(st_reg[S_CLIP2-1].hi[k]);
        end
        st_next[S_CLIP2].tmin = tlo[rosi_pkg::TMIN_W-1:0];
        st_next[S_CLIP2].hit  = !st_reg[S_CLIP2-1].zero && !st_reg[S_CLIP2-1].par_miss
                                && (tlo <= thi);

        // scale direction by entry distance
        tm_s = $signed({1'b0, st_reg[S_MUL2-1].tmin});
        for (int k = 0; k < 3; k++)
        begin
            mpd = $signed(st_reg[S_MUL2-1].d[k]) * tm_s;
            mpq = $signed(st_reg[S_MUL2-1].q[k]) * tm_s;
            st_next[S_MUL2].pd[k] = mpd;
            st_next[S_MUL2].pq[k] = mpq;
        end

        // world hit point, box-space hit point, face distances
        for (int k = 0; k < 3; k++)
        begin
            hsum = ($bits(hsum))'($signed(st_reg[S_FIN1-1].o[k])) + ($bits(hsum))'(hq[k]);
            if (hsum > ($bits(hsum))'(32767))
                st_next[S_FIN1].hp[k] = 16'h7FFF;
            else if (hsum < -($bits(hsum))'(32768))
                st_next[S_FIN1].hp[k] = 16'h8000;
            else
                st_next[S_FIN1].hp[k] = hsum[CW-1:0];
            lsum = rosi_pkg::LOC_W'($signed(st_reg[S_FIN1-1].p[k])) + rosi_pkg::LOC_W'(lq[k]);
            labs = lsum[rosi_pkg::LOC_W-1] ? -lsum : lsum;
            st_next[S_FIN1].loc[k] = lsum;
            st_next[S_FIN1].bd[k]  = rosi_pkg::BD_W'(labs) - rosi_pkg::BD_W'(h_s[k]);
        end

        // face pick, ties to x then y then z
        bd0 = $signed(st_reg[S_FIN2-1].bd[0]);
        bd1 = $signed(st_reg[S_FIN2-1].bd[1]);
        bd2 = $signed(st_reg[S_FIN2-1].bd[2]);
        if (bd0 >= bd1 && bd0 >= bd2)
            sel = 2'd0;
        else if (bd1 >= bd2)
            sel = 2'd1;
        else
            sel = 2'd2;
        for (int i = 0; i < 3; i++)
        begin
            a = ax_s[sel][i];
            if ($signed(st_reg[S_FIN2-1].loc[sel]) > 0)
                st_next[S_FIN2].nrm[i] = a;
            else if (a == 16'sh8000)
                st_next[S_FIN2].nrm[i] = 16'h7FFF;
            else
                st_next[S_FIN2].nrm[i] = -a;
        end
        st_next[S_FIN2].hdist = st_reg[S_FIN2-1].tmin[rosi_pkg::TMIN_W-1:8];
        if (!st_reg[S_FIN2-1].hit)
        begin
            st_next[S_FIN2].hdist = '0;
            st_next[S_FIN2].hp    = '0;
            st_next[S_FIN2].nrm   = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < NST; s++)
                st_reg[s] <= st_next[s];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NST-2:0], s_axis_tvalid};
    end

    assign m_axis_tvalid = vld_reg[NST-1];
    assign m_axis_tdata  = {st_reg[NST-1].nrm[2], st_reg[NST-1].nrm[1], st_reg[NST-1].nrm[0],
                            st_reg[NST-1].hp[2], st_reg[NST-1].hp[1], st_reg[NST-1].hp[0],
                            st_reg[NST-1].hdist, st_reg[NST-1].hit};

    // a miss carries all-zero fields
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[111:1] == '0)
        else $error("miss result with nonzero fields");

    // a hit lies inside the requested distance
    a_hit_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[S_CLIP2] && st_reg[S_CLIP2].hit
        |-> st_reg[S_CLIP2].tmin <= {st_reg[S_CLIP2].maxd, 8'b0})
        else $error("hit beyond max distance");

    // zero direction never hits
    a_zero_miss: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[S_CLIP2] && st_reg[S_CLIP2].zero |-> !st_reg[S_CLIP2].hit)
        else $error("zero direction reported a hit");

    // an enabled request in the hit point stage reaches the output register next cycle
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        en && vld_reg[S_FIN1] |=> vld_reg[S_FIN2])
        else $error("request lost between final stages");

endmodule

### sv/rosi_div.sv
// Pipelined signed divider, one quotient bit per stage, truncating toward zero.
// Saturates the quotient magnitude to QW bits. Uses rosi_pkg only for parameter defaults.
module rosi_div #(
    parameter int NW = rosi_pkg::NUM1_W,
    parameter int DW = rosi_pkg::Q_W,
    parameter int QW = rosi_pkg::QW1
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [NW-1:0] num,
    input  logic signed [DW-1:0] den,
    output logic signed [QW:0]   quo
);

    localparam int RW = (NW > DW + QW) ? NW : DW + QW;

    logic [NW-1:0] a_num_reg;
    logic [DW-1:0] a_den_reg;
    logic          a_neg_reg;
    logic [NW-1:0] b_num_reg;
    logic [DW-1:0] b_den_reg;
    logic          b_neg_reg;
    logic          b_ovf_reg;

    logic [RW-1:0] rem_reg  [QW];
    logic [QW-1:0] qt_reg   [QW];
    logic [DW-1:0] dv_reg   [QW];
    logic          ng_reg   [QW];
    logic          ov_reg   [QW];
    logic [RW-1:0] rem_next [QW];
    logic [QW-1:0] qt_next  [QW];
    logic signed [QW:0] quo_reg;
    logic signed [QW:0] quo_next;

    logic [NW-1:0] nu;
    logic [DW-1:0] du;

    assign nu = num;
    assign du = den;

    always_comb
    begin
        logic [RW-1:0] rin;
        logic [QW-1:0] qin;
        logic [RW-1:0] sub;
        logic [QW-1:0] qv;
        for (int j = 0; j < QW; j++)
        begin
            rin = (j == 0) ? RW'(b_num_reg) : rem_reg[j-1];
            qin = (j == 0) ? '0 : qt_reg[j-1];
            sub = RW'((j == 0) ? b_den_reg : dv_reg[j-1]) << (QW - 1 - j);
            if (rin >= sub)
            begin
                rem_next[j] = rin - sub;
                qt_next[j]  = qin | (QW'(1) << (QW - 1 - j));
            end
            else
            begin
                rem_next[j] = rin;
                qt_next[j]  = qin;
            end
        end
        qv = ov_reg[QW-1] ? {QW{1'b1}} : qt_reg[QW-1];
        quo_next = ng_reg[QW-1] ? -$signed({1'b0, qv}) : $signed({1'b0, qv});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_num_reg <= nu[NW-1] ? (~nu + NW'(1)) : nu;
            a_den_reg <= du[DW-1] ? (~du + DW'(1)) : du;
            a_neg_reg <= nu[NW-1] ^ du[DW-1];
            b_num_reg <= a_num_reg;
            b_den_reg <= a_den_reg;
            b_neg_reg <= a_neg_reg;
            b_ovf_reg <= RW'(a_num_reg) >= (RW'(a_den_reg) << QW);
            for (int j = 0; j < QW; j++)
            begin
                rem_reg[j] <= rem_next[j];
                qt_reg[j]  <= qt_next[j];
                dv_reg[j]  <= (j == 0) ? b_den_reg : dv_reg[j-1];
                ng_reg[j]  <= (j == 0) ? b_neg_reg : ng_reg[j-1];
                ov_reg[j]  <= (j == 0) ? b_ovf_reg : ov_reg[j-1];
            end
            quo_reg <= quo_next;
        end
    end

    assign quo = quo_reg;

endmodule
